>>> rtl/dmas_pkg.sv
// Shared types, constants and helpers for the DNA motif anchor scanner.
// No dependencies; used by dmas_cell and dna_motif_anchor_scanner_top.
package dmas_pkg;

  // Default sizing
  localparam int MAX_MOTIF_LEN = 8;
  localparam int MAX_MOTIFS    = 4;
  localparam int POS_WIDTH     = 32;

  // Fixed register file layout
  localparam int MOTIF_REGS = 4;
  localparam int WORD_W     = 24;
  localparam int BASE_W     = 3;
  localparam int GEO_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int ANCHOR_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MOTIF_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTIF_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOTIF_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTIF_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOTIFS_IN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STRAND    = 3'd7;

  localparam logic [1:0] STRAND_FWD = 2'd0;
  localparam logic [1:0] STRAND_REV = 2'd1;

  typedef struct packed {
    logic [BASE_W-1:0] base_code;
    logic              sequence_start;
  } in_item_t;

  typedef struct packed {
    logic                anchor_valid;
    logic [ANCHOR_W-1:0] anchor_position;
    logic                motif_hit;
    logic                forward_hit;
    logic                reverse_hit;
    logic [1:0]          motif_index;
  } out_item_t;

  // Window shift control, common to all cells
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // Saturated motif geometry: length, anchor offset, lookahead
  typedef struct packed {
    logic [GEO_W-1:0] len;
    logic [GEO_W-1:0] off;
    logic [GEO_W-1:0] look;
  } geo_t;

  // A<->T, C<->G; other codes map to themselves
  function automatic logic [BASE_W-1:0] comp_base(input logic [BASE_W-1:0] b);
    return (b < 3'd4) ? (3'd3 - b) : b;
  endfunction

  // Base j of a motif word; bases beyond the word read as A
  function automatic logic [BASE_W-1:0] motif_base(input logic [WORD_W-1:0] w,
                                                   input logic [GEO_W-1:0] j);
    logic [6:0] sh;
    sh = 7'(j) * 7'd3;
    return (j < 5'd8) ? BASE_W'(w >> sh) : '0;
  endfunction

endpackage

>>> rtl/dmas_cell.sv
// One window cell: holds a single base, passes it to the next cell on a shift,
// and compares it against the motif base that lands on its slot. Uses dmas_pkg.
module dmas_cell #(
  parameter int IDX     = 0,
  parameter int NUM_CMP = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dmas_pkg::cell_ctl_t           ctl,
  input  logic [dmas_pkg::BASE_W-1:0]   base_in,
  input  dmas_pkg::geo_t                geo,
  input  logic [dmas_pkg::WORD_W-1:0]   motif_w [dmas_pkg::MOTIF_REGS],
  output logic [dmas_pkg::BASE_W-1:0]   base_out,
  output logic [NUM_CMP-1:0]            fwd_ok,
  output logic [NUM_CMP-1:0]            rev_ok
);

  localparam logic [5:0] POS = 6'(IDX);

  logic [dmas_pkg::BASE_W-1:0] base_r, base_nxt;
  logic [5:0] fwd_top, rev_sum, jf, jr;
  logic       jf_in, jr_in;

  always_comb begin
    base_nxt = base_r;
    if (ctl.shift) begin
      base_nxt = (ctl.clear && IDX != 0) ? '0 : base_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else begin
      base_r <= base_nxt;
    end
  end

  assign base_out = base_r;

  // Forward motif base jf = look + off - 1 - IDX; reverse jr = IDX + off - 1 - look
  always_comb begin
    fwd_top = 6'(geo.look) + 6'(geo.off) - 6'd1;
    rev_sum = POS + 6'(geo.off) - 6'd1;
    jf      = fwd_top - POS;
    jr      = rev_sum - 6'(geo.look);
    jf_in   = (fwd_top >= POS) && (jf < 6'(geo.len));
    jr_in   = (rev_sum >= 6'(geo.look)) && (jr < 6'(geo.len));
    for (int k = 0; k < NUM_CMP; k++) begin
      fwd_ok[k] = !jf_in ||
                  (base_r == dmas_pkg::motif_base(motif_w[k], jf[dmas_pkg::GEO_W-1:0]));
      rev_ok[k] = !jr_in ||
                  (dmas_pkg::comp_base(base_r) ==
                   dmas_pkg::motif_base(motif_w[k], jr[dmas_pkg::GEO_W-1:0]));
    end
  end

endmodule

>>> rtl/dna_motif_anchor_scanner_top.sv
// Top level of the DNA motif anchor scanner: config registers, window cell
// chain, hit resolution and output register. Uses dmas_pkg and dmas_cell.
//
//   port group  direction  handshake         payload
//   in_*        input      in_valid/in_stall  dmas_pkg::in_item_t
//   out_*       output     out_valid/out_stall dmas_pkg::out_item_t
//   cfg_*       input      cfg_we             cfg_idx, cfg_wdata
//
// One base per cycle while in_stall is low; each accepted base gives one result.
// The base is first shifted into the cell chain; the compare stage then checks
// all cells against all motifs in parallel and loads the output register.
// rst_n (synchronous) clears the window and position count and resets the config.
// out_stall holds the output register; a new base is still taken while the
// compare stage is empty or can move into the output register.
module dna_motif_anchor_scanner_top #(
  parameter int MAX_MOTIF_LEN = dmas_pkg::MAX_MOTIF_LEN,
  parameter int MAX_MOTIFS    = dmas_pkg::MAX_MOTIFS,
  parameter int POS_WIDTH     = dmas_pkg::POS_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dmas_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dmas_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [dmas_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dmas_pkg::WORD_W-1:0]     cfg_wdata
);

  localparam int DEPTH   = 2 * MAX_MOTIF_LEN;
  localparam int NUM_CMP = (MAX_MOTIFS < dmas_pkg::MOTIF_REGS) ? MAX_MOTIFS
                                                               : dmas_pkg::MOTIF_REGS;
  localparam logic [dmas_pkg::GEO_W-1:0] LEN_MAX = dmas_pkg::GEO_W'(MAX_MOTIF_LEN);
  localparam logic [2:0]                 NM_MAX  = 3'(NUM_CMP);

  // Configuration registers
  logic [dmas_pkg::WORD_W-1:0] motif_w_r [dmas_pkg::MOTIF_REGS];
  logic [2:0] motifs_in_use_r;
  logic [3:0] motif_length_r;
  logic [3:0] mutation_offset_r;
  logic [1:0] strand_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < dmas_pkg::MOTIF_REGS; k++) begin
        motif_w_r[k] <= '0;
      end
      motifs_in_use_r   <= 3'd1;
      motif_length_r    <= 4'd1;
      mutation_offset_r <= 4'd1;
      strand_mode_r     <= dmas_pkg::STRAND_FWD;
    end else if (cfg_we) begin
      case (cfg_idx)
        dmas_pkg::REG_MOTIF_0:   motif_w_r[0]      <= cfg_wdata;
        dmas_pkg::REG_MOTIF_1:   motif_w_r[1]      <= cfg_wdata;
        dmas_pkg::REG_MOTIF_2:   motif_w_r[2]      <= cfg_wdata;
        dmas_pkg::REG_MOTIF_3:   motif_w_r[3]      <= cfg_wdata;
        dmas_pkg::REG_MOTIFS_IN: motifs_in_use_r   <= cfg_wdata[2:0];
        dmas_pkg::REG_LENGTH:    motif_length_r    <= cfg_wdata[3:0];
        dmas_pkg::REG_OFFSET:    mutation_offset_r <= cfg_wdata[3:0];
        dmas_pkg::REG_STRAND:    strand_mode_r     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Saturated geometry
  dmas_pkg::geo_t geo;
  logic [dmas_pkg::GEO_W-1:0] len_raw, off_raw, lo_span, hi_span;
  logic [2:0] nm;

  always_comb begin
    len_raw = dmas_pkg::GEO_W'(motif_length_r);
    off_raw = dmas_pkg::GEO_W'(mutation_offset_r);
    geo.len = (len_raw == '0) ? dmas_pkg::GEO_W'(1) :
              ((len_raw > LEN_MAX) ? LEN_MAX : len_raw);
    geo.off = (off_raw == '0) ? dmas_pkg::GEO_W'(1) :
              ((off_raw > geo.len) ? geo.len : off_raw);
    lo_span  = geo.off - dmas_pkg::GEO_W'(1);
    hi_span  = geo.len - geo.off;
    geo.look = (lo_span > hi_span) ? lo_span : hi_span;
    nm = (motifs_in_use_r == '0) ? 3'd1 :
         ((motifs_in_use_r > NM_MAX) ? NM_MAX : motifs_in_use_r);
  end

  // Handshake: the compare stage moves on when the output register is free
  logic s1_v_r, s1_v_nxt;
  logic out_valid_r, out_valid_nxt;
  logic adv, in_xfer;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_v_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_xfer) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
    out_valid_nxt = adv ? s1_v_r : out_valid_r;
  end

  // Position counter, saturating
  logic [POS_WIDTH-1:0] seen_r, seen_nxt, seen_base;

  always_comb begin
    seen_base = in_data.sequence_start ? '0 : seen_r;
    seen_nxt  = seen_r;
    if (in_xfer) begin
      seen_nxt = (&seen_base) ? seen_base : seen_base + POS_WIDTH'(1);
    end
  end

  // Cell chain
  dmas_pkg::cell_ctl_t ctl;
  logic [dmas_pkg::BASE_W-1:0] win [DEPTH];
  logic [NUM_CMP-1:0] fwd_ok [DEPTH];
  logic [NUM_CMP-1:0] rev_ok [DEPTH];

  assign ctl.shift = in_xfer;
  assign ctl.clear = in_data.sequence_start;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dmas_cell #(
      .IDX     (i),
      .NUM_CMP (NUM_CMP)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .base_in  ((i == 0) ? in_data.base_code : win[(i == 0) ? 0 : i - 1]),
      .geo      (geo),
      .motif_w  (motif_w_r),
      .base_out (win[i]),
      .fwd_ok   (fwd_ok[i]),
      .rev_ok   (rev_ok[i])
    );
  end

  // Hit resolution
  logic [NUM_CMP-1:0] fwd_eq, rev_eq;
  logic fhit, rhit, win_full;
  logic [1:0] fidx, ridx;
  logic [POS_WIDTH-1:0] anchor_full;
  logic [POS_WIDTH+dmas_pkg::ANCHOR_W-1:0] anchor_ext;
  logic [5:0] need;
  logic do_fwd, do_rev;
  dmas_pkg::out_item_t res, out_data_r;

  always_comb begin
    do_fwd = strand_mode_r != dmas_pkg::STRAND_REV;
    do_rev = strand_mode_r != dmas_pkg::STRAND_FWD;
    for (int k = 0; k < NUM_CMP; k++) begin
      fwd_eq[k] = 3'(k) < nm;
      rev_eq[k] = 3'(k) < nm;
      for (int i = 0; i < DEPTH; i++) begin
        fwd_eq[k] = fwd_eq[k] & fwd_ok[i][k];
        rev_eq[k] = rev_eq[k] & rev_ok[i][k];
      end
    end
    fhit = 1'b0;
    rhit = 1'b0;
    fidx = '0;
    ridx = '0;
    for (int k = NUM_CMP - 1; k >= 0; k--) begin
      if (do_fwd && fwd_eq[k]) begin
        fhit = 1'b1;
        fidx = 2'(k);
      end
      if (do_rev && rev_eq[k]) begin
        rhit = 1'b1;
        ridx = 2'(k);
      end
    end
    need        = {geo.look, 1'b0} + 6'd1;
    win_full    = seen_r >= POS_WIDTH'(need);
    anchor_full = seen_r - POS_WIDTH'(geo.look);
    anchor_ext  = {{dmas_pkg::ANCHOR_W{1'b0}}, anchor_full};

    res = '0;
    if (win_full) begin
      res.anchor_valid    = 1'b1;
      res.anchor_position = anchor_ext[dmas_pkg::ANCHOR_W-1:0];
      res.motif_hit       = fhit || rhit;
      res.forward_hit     = fhit;
      res.reverse_hit     = rhit;
      res.motif_index     = rhit ? ridx : (fhit ? fidx : 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
      seen_r      <= seen_nxt;
    end
  end

  // Load the result when the compare stage transfers into the output register
  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
